@@ rtl/page_map_and_walk_top_assert.svh @@
// Assertion macros used by the page map and walk RTL.
`ifndef PAGE_MAP_AND_WALK_TOP_ASSERT_SVH
`define PAGE_MAP_AND_WALK_TOP_ASSERT_SVH

`ifndef SYNTH
`define PMW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PMW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PMW_ASSERT_IMP(lbl, ante, cons, msg)
`define PMW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/pmw_pkg.sv @@
// Types, constants and helper functions of the page map and walk block.
package pmw_pkg;

    // Page memory depth in 32-bit words; kept a power of two.
    localparam int MEM_WORDS  = 16384;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int CFG_ADDR_W = 4;

    localparam logic [31:0] FLAG_PRESENT  = 32'h0000_0001;
    localparam logic [31:0] FLAG_WRITABLE = 32'h0000_0002;
    localparam logic [31:0] FLAG_USER     = 32'h0000_0004;
    localparam logic [31:0] FLAG_GLOBAL   = 32'h0000_0100;
    localparam logic [31:0] FRAME_MASK    = 32'hFFFF_F000;

    localparam logic [31:0] USER_LIMIT_RST = 32'hC000_0000;

    typedef logic [ADDR_W-1:0] t_waddr;

    typedef enum logic [1:0] {
        REQ_MAP_PTE,
        REQ_MAP_PDE,
        REQ_RESOLVE,
        REQ_RAW_WRITE
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DENIED,
        ST_IGNORED
    } t_status;

    typedef enum logic [1:0] {
        REG_USER_LIMIT,
        REG_REMAP_BASE,
        REG_REMAP_LEN,
        REG_BOOT_DIR
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIR,
        S_TAB
    } t_state;

    typedef struct packed {
        logic [31:0] user_limit;
        logic [31:0] remap_base;
        logic [31:0] remap_len;
        logic [31:0] boot_dir;
    } t_cfg;

    typedef struct packed {
        t_req        req_type;
        logic [31:0] directory_base;
        logic [31:0] table_addr;
        logic [31:0] frame_addr;
        logic [31:0] virt_addr;
        logic        attr_writable;
        logic        attr_present;
        logic        attr_kernel;
        logic [31:0] mem_addr;
        logic [31:0] mem_data;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] phys_frame;
        logic [31:0] table_phys;
    } t_result;

    typedef struct packed {
        logic        we;
        logic        re;
        t_waddr      addr;
        logic [31:0] wdata;
    } t_mem_req;

    function automatic logic [31:0] make_flags(logic wr, logic pr, logic kern);
        logic [31:0] f;
        f = '0;
        if (wr) f = f | FLAG_WRITABLE;
        if (pr) f = f | FLAG_PRESENT;
        f = f | (kern ? FLAG_GLOBAL : FLAG_USER);
        return f;
    endfunction

    function automatic logic access_ok(logic [31:0] entry, logic wr, logic kern);
        return entry[0] && (kern || entry[2]) && (!wr || entry[1]);
    endfunction

    function automatic logic map_allowed(logic [31:0] va, t_cfg cfg);
        logic [32:0] win_end;
        win_end = {1'b0, cfg.remap_base} + {1'b0, cfg.remap_len};
        return (va < cfg.user_limit) ||
               ((va >= cfg.remap_base) && ({1'b0, va} < win_end));
    endfunction

endpackage

@@ rtl/page_map_and_walk_top.sv @@
// Top level of the page map and walk block.
//
// One request at a time. A resolve that passes the directory level goes
// through accept with directory read, table read and result, set by the two
// dependent reads of the single page memory; a resolve denied at the
// directory level and map and raw write requests go through accept and
// result only. The result sits in an output register, so the next request
// is accepted while it waits; a full one stalls the result step. The page
// memory is not cleared after reset: write directories and tables (the raw
// word write serves for clearing) before resolving through them.
module page_map_and_walk_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // directory_base, table_addr, frame_addr, virt_addr, attr_writable,
    // attr_present, attr_kernel, mem_addr, mem_data, zero pad
    input  logic [199:0]                    s_axis_tdata,
    // req_type
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // phys_frame, table_phys
    output logic [63:0]                     m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    pmw_pkg::t_cfg     cfg;
    pmw_pkg::t_item    item;
    pmw_pkg::t_result  result;
    pmw_pkg::t_mem_req mem_req;
    logic [31:0]       mem_rdata;

    assign item.req_type       = pmw_pkg::t_req'(s_axis_tuser);
    assign item.directory_base = s_axis_tdata[31:0];
    assign item.table_addr     = s_axis_tdata[63:32];
    assign item.frame_addr     = s_axis_tdata[95:64];
    assign item.virt_addr      = s_axis_tdata[127:96];
    assign item.attr_writable  = s_axis_tdata[128];
    assign item.attr_present   = s_axis_tdata[129];
    assign item.attr_kernel    = s_axis_tdata[130];
    assign item.mem_addr       = s_axis_tdata[162:131];
    assign item.mem_data       = s_axis_tdata[194:163];

    pmw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pmw_ram #(
        .WIDTH (32),
        .DEPTH (pmw_pkg::MEM_WORDS)
    ) u_page_mem (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    pmw_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    assign m_axis_tdata = {result.table_phys, result.phys_frame};
    assign m_axis_tuser = result.status;

endmodule

@@ rtl/pmw_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module pmw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pmw_cfg.sv @@
// APB configuration registers of the page map and walk block.
module pmw_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmw_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output pmw_pkg::t_cfg                   o_cfg
);

    pmw_pkg::t_cfg    r_cfg;
    pmw_pkg::t_cfg    n_cfg;
    pmw_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = pmw_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                pmw_pkg::REG_USER_LIMIT: n_cfg.user_limit = pwdata;
                pmw_pkg::REG_REMAP_BASE: n_cfg.remap_base = pwdata;
                pmw_pkg::REG_REMAP_LEN:  n_cfg.remap_len  = pwdata;
                pmw_pkg::REG_BOOT_DIR:   n_cfg.boot_dir   = pwdata;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pmw_pkg::REG_USER_LIMIT: prdata = r_cfg.user_limit;
            pmw_pkg::REG_REMAP_BASE: prdata = r_cfg.remap_base;
            pmw_pkg::REG_REMAP_LEN:  prdata = r_cfg.remap_len;
            pmw_pkg::REG_BOOT_DIR:   prdata = r_cfg.boot_dir;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.user_limit <= pmw_pkg::USER_LIMIT_RST;
            r_cfg.remap_base <= '0;
            r_cfg.remap_len  <= '0;
            r_cfg.boot_dir   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pmw_walk.sv @@
// Request sequencer: map writes, raw writes and the two-level table walk.
`include "page_map_and_walk_top_assert.svh"

module pmw_walk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmw_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pmw_pkg::t_item     i_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pmw_pkg::t_result   o_result,
    output pmw_pkg::t_mem_req  o_mem_req,
    input  logic [31:0]        i_mem_rdata
);

    pmw_pkg::t_state   r_state;
    pmw_pkg::t_state   n_state;
    pmw_pkg::t_item    r_item;
    pmw_pkg::t_item    n_item;
    logic [31:0]       r_tphys;
    logic [31:0]       n_tphys;
    logic              r_out_valid;
    logic              n_out_valid;
    pmw_pkg::t_result  r_result;
    pmw_pkg::t_result  n_result;

    logic              out_free;
    logic              load_out;
    logic              dir_ok;
    logic              tab_ok;
    logic              allowed;
    logic [31:0]       in_dir;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_dir   = (i_item.directory_base == '0) ? i_cfg.boot_dir : i_item.directory_base;
    assign dir_ok   = pmw_pkg::access_ok(i_mem_rdata, r_item.attr_writable, r_item.attr_kernel);
    assign tab_ok   = dir_ok;
    assign allowed  = pmw_pkg::map_allowed(r_item.virt_addr, i_cfg);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_item.req_type == pmw_pkg::REQ_RESOLVE) ?
                              pmw_pkg::S_DIR : pmw_pkg::S_EXEC;
                end
            end
            pmw_pkg::S_EXEC: begin
                if (out_free) n_state = pmw_pkg::S_IDLE;
            end
            pmw_pkg::S_DIR: begin
                if (dir_ok) begin
                    n_state = pmw_pkg::S_TAB;
                end else if (out_free) begin
                    n_state = pmw_pkg::S_IDLE;
                end
            end
            pmw_pkg::S_TAB: begin
                if (out_free) n_state = pmw_pkg::S_IDLE;
            end
            default: n_state = pmw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_mem_req  = '0;
        n_item     = r_item;
        n_tphys    = r_tphys;
        load_out   = 1'b0;
        n_result   = r_result;
        o_in_ready = 1'b0;
        unique case (r_state)
            pmw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item                = i_item;
                    n_item.directory_base = in_dir;
                    if (i_item.req_type == pmw_pkg::REQ_RESOLVE) begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = in_dir[pmw_pkg::ADDR_W+1:2] +
                                         pmw_pkg::t_waddr'(i_item.virt_addr[31:22]);
                    end
                end
            end
            pmw_pkg::S_EXEC: begin
                if (out_free) begin
                    load_out            = 1'b1;
                    n_result.phys_frame = '0;
                    n_result.table_phys = '0;
                    n_result.status     = pmw_pkg::ST_OK;
                    case (r_item.req_type)
                        pmw_pkg::REQ_MAP_PTE: begin
                            o_mem_req.we    = allowed;
                            o_mem_req.addr  = r_item.table_addr[pmw_pkg::ADDR_W+1:2] +
                                              pmw_pkg::t_waddr'(r_item.virt_addr[21:12]);
                            o_mem_req.wdata = (r_item.frame_addr & pmw_pkg::FRAME_MASK) |
                                              pmw_pkg::make_flags(r_item.attr_writable,
                                                                  r_item.attr_present,
                                                                  r_item.attr_kernel);
                            if (!allowed) n_result.status = pmw_pkg::ST_IGNORED;
                        end
                        pmw_pkg::REQ_MAP_PDE: begin
                            o_mem_req.we    = allowed;
                            o_mem_req.addr  = r_item.directory_base[pmw_pkg::ADDR_W+1:2] +
                                              pmw_pkg::t_waddr'(r_item.virt_addr[31:22]);
                            o_mem_req.wdata = (r_item.table_addr & pmw_pkg::FRAME_MASK) |
                                              pmw_pkg::make_flags(r_item.attr_writable,
                                                                  r_item.attr_present,
                                                                  r_item.attr_kernel);
                            if (!allowed) n_result.status = pmw_pkg::ST_IGNORED;
                        end
                        default: begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.addr  = r_item.mem_addr[pmw_pkg::ADDR_W+1:2];
                            o_mem_req.wdata = r_item.mem_data;
                        end
                    endcase
                end
            end
            pmw_pkg::S_DIR: begin
                if (dir_ok) begin
                    n_tphys        = i_mem_rdata & pmw_pkg::FRAME_MASK;
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = n_tphys[pmw_pkg::ADDR_W+1:2] +
                                     pmw_pkg::t_waddr'(r_item.virt_addr[21:12]);
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_result = '{status: pmw_pkg::ST_DENIED, phys_frame: '0, table_phys: '0};
                end
            end
            pmw_pkg::S_TAB: begin
                if (out_free) begin
                    load_out            = 1'b1;
                    n_result.table_phys = r_tphys;
                    if (tab_ok) begin
                        n_result.status     = pmw_pkg::ST_OK;
                        n_result.phys_frame = i_mem_rdata & pmw_pkg::FRAME_MASK;
                    end else begin
                        n_result.status     = pmw_pkg::ST_DENIED;
                        n_result.phys_frame = '0;
                    end
                end
            end
            default: begin
                o_mem_req = '0;
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_tphys  <= n_tphys;
        r_result <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `PMW_ASSERT_IMP(a_write_in_exec, o_mem_req.we, r_state == pmw_pkg::S_EXEC, "write outside exec")
    `PMW_ASSERT_IMP(a_no_overwrite, load_out && r_out_valid, i_out_ready, "result overwritten")
    `PMW_ASSERT_IMP(a_resolve_reads, i_in_valid && o_in_ready && i_item.req_type == pmw_pkg::REQ_RESOLVE, o_mem_req.re, "resolve without directory read")
    `PMW_ASSERT_IMP(a_tab_read_ok, o_mem_req.re && r_state == pmw_pkg::S_DIR, dir_ok, "table read after denied directory entry")
    `PMW_ASSERT_NXT(a_tab_from_dir, r_state == pmw_pkg::S_DIR && dir_ok, r_state == pmw_pkg::S_TAB, "walk skipped table level")

endmodule
